// ===== rtl/bac_pkg.sv =====
// ----------------------------------------------------------------------------
// bac_pkg
// Shared types, mode codes and BCD step functions for the alarm clock.
// ----------------------------------------------------------------------------
package bac_pkg;

  localparam logic [7:0] TPS_RESET = 8'd10;
  localparam logic [5:0] SEC_LAST  = 6'd59;

  localparam logic [2:0] MODE_NORMAL   = 3'd0;
  localparam logic [2:0] MODE_SET_MIN  = 3'd1;
  localparam logic [2:0] MODE_SET_HOUR = 3'd2;
  localparam logic [2:0] MODE_ALM_MIN  = 3'd3;
  localparam logic [2:0] MODE_ALM_HOUR = 3'd4;
  localparam logic [2:0] MODE_ALM_EN   = 3'd5;

  localparam int unsigned InDataW  = 8;
  localparam int unsigned OutDataW = 24;

  typedef struct packed {
    logic [3:0] mu;
    logic [2:0] mt;
    logic [3:0] hu;
    logic [1:0] ht;
  } bcd_time_t;

  typedef struct packed {
    logic op;
    logic mode_press;
    logic inc_press;
    logic dec_press;
  } event_t;

  // packed from the top down, so shown_hour_tens sits in the low bits
  typedef struct packed {
    logic       alarm_set_led;
    logic       time_set_led;
    logic       alarm_ringing;
    logic       alarm_on;
    logic [2:0] current_mode;
    logic [3:0] shown_minute_units;
    logic [2:0] shown_minute_tens;
    logic [3:0] shown_hour_units;
    logic [1:0] shown_hour_tens;
  } result_t;

  function automatic bcd_time_t min_up(bcd_time_t t);
    bcd_time_t r;
    r = t;
    if (t.mu < 4'd9) begin
      r.mu = t.mu + 4'd1;
    end else begin
      r.mu = 4'd0;
      if (t.mt < 3'd5) r.mt = t.mt + 3'd1;
      else r.mt = 3'd0;
    end
    return r;
  endfunction

  function automatic logic min_carry(bcd_time_t t);
    return (t.mu >= 4'd9) && (t.mt >= 3'd5);
  endfunction

  function automatic bcd_time_t min_down(bcd_time_t t);
    bcd_time_t r;
    r = t;
    if (t.mu > 4'd0) begin
      r.mu = t.mu - 4'd1;
    end else begin
      r.mu = 4'd9;
      if (t.mt > 3'd0) r.mt = t.mt - 3'd1;
      else r.mt = 3'd5;
    end
    return r;
  endfunction

  function automatic bcd_time_t hour_up(bcd_time_t t);
    bcd_time_t r;
    r = t;
    if (t.ht >= 2'd2 && t.hu >= 4'd3) begin
      r.ht = 2'd0;
      r.hu = 4'd0;
    end else if (t.hu < 4'd9) begin
      r.hu = t.hu + 4'd1;
    end else begin
      r.hu = 4'd0;
      r.ht = t.ht + 2'd1;
    end
    return r;
  endfunction

  function automatic bcd_time_t hour_down(bcd_time_t t);
    bcd_time_t r;
    r = t;
    if (t.hu > 4'd0) begin
      r.hu = t.hu - 4'd1;
    end else if (t.ht > 2'd0) begin
      r.hu = 4'd9;
      r.ht = t.ht - 2'd1;
    end else begin
      r.ht = 2'd2;
      r.hu = 4'd3;
    end
    return r;
  endfunction

endpackage

// ===== rtl/bac_in_stage.sv =====
// ----------------------------------------------------------------------------
// bac_in_stage
// Input register holding one event word until the core takes it.
// ----------------------------------------------------------------------------
module bac_in_stage (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            valid_i,
  output logic            ready_o,
  input  bac_pkg::event_t item_i,
  input  logic            take_i,
  output logic            valid_o,
  output bac_pkg::event_t item_o
);
  import bac_pkg::*;

  logic   valid_q, valid_d;
  event_t item_q;
  logic   load;

  assign ready_o = !valid_q || take_i;
  assign load    = valid_i && ready_o;

  always_comb begin
    valid_d = valid_q;
    if (load) valid_d = 1'b1;
    else if (take_i) valid_d = 1'b0;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) valid_q <= 1'b0;
    else valid_q <= valid_d;
  end

  always_ff @(posedge clk_i) begin
    if (load) item_q <= item_i;
  end

  assign valid_o = valid_q;
  assign item_o  = item_q;

endmodule

// ===== rtl/bac_core.sv =====
// ----------------------------------------------------------------------------
// bac_core
// Clock, alarm and mode state with the single-pass update for one event.
// ----------------------------------------------------------------------------
module bac_core (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             cfg_we_i,
  input  logic [7:0]       cfg_data_i,
  input  logic             fire_i,
  input  bac_pkg::event_t  item_i,
  output bac_pkg::result_t result_o
);
  import bac_pkg::*;

  logic [7:0] tps_q;
  logic [7:0] tick_q, tick_d;
  logic [5:0] sec_q, sec_d;
  bcd_time_t  clk_q, clk_d;
  bcd_time_t  alm_q, alm_d;
  logic       alarm_en_q, alarm_en_d;
  logic [2:0] mode_q, mode_d;
  logic       firing_q, firing_d;
  logic       press;
  logic       alm_view;
  bcd_time_t  shown;

  always_comb begin
    tick_d     = tick_q;
    sec_d      = sec_q;
    clk_d      = clk_q;
    alm_d      = alm_q;
    alarm_en_d = alarm_en_q;
    mode_d     = mode_q;
    firing_d   = firing_q;
    press      = 1'b0;
    if (item_i.op) begin
      if (item_i.mode_press) begin
        mode_d = (mode_q >= MODE_ALM_EN) ? MODE_NORMAL : mode_q + 3'd1;
      end
      // increment first, then decrement
      for (int k = 0; k < 2; k++) begin
        press = (k == 0) ? item_i.inc_press : item_i.dec_press;
        if (press) begin
          case (mode_d)
            MODE_SET_MIN:  clk_d = (k == 0) ? min_up(clk_d) : min_down(clk_d);
            MODE_SET_HOUR: clk_d = (k == 0) ? hour_up(clk_d) : hour_down(clk_d);
            MODE_ALM_MIN:  alm_d = (k == 0) ? min_up(alm_d) : min_down(alm_d);
            MODE_ALM_HOUR: alm_d = (k == 0) ? hour_up(alm_d) : hour_down(alm_d);
            MODE_ALM_EN:   alarm_en_d = ~alarm_en_d;
            default:       ;
          endcase
        end
      end
    end else begin
      if (({1'b0, tick_q} + 9'd1) < {1'b0, tps_q}) begin
        tick_d = tick_q + 8'd1;
      end else begin
        tick_d = 8'd0;
        if (sec_q < SEC_LAST) begin
          sec_d = sec_q + 6'd1;
        end else begin
          sec_d = 6'd0;
          clk_d = min_up(clk_q);
          if (min_carry(clk_q)) clk_d = hour_up(clk_d);
          firing_d = alarm_en_q && (clk_d == alm_q);
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tps_q <= TPS_RESET;
    end else if (cfg_we_i) begin
      tps_q <= cfg_data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tick_q     <= '0;
      sec_q      <= '0;
      clk_q      <= '0;
      alm_q      <= '0;
      alarm_en_q <= 1'b0;
      mode_q     <= MODE_NORMAL;
      firing_q   <= 1'b0;
    end else if (fire_i) begin
      tick_q     <= tick_d;
      sec_q      <= sec_d;
      clk_q      <= clk_d;
      alm_q      <= alm_d;
      alarm_en_q <= alarm_en_d;
      mode_q     <= mode_d;
      firing_q   <= firing_d;
    end
  end

  assign alm_view = (mode_d == MODE_ALM_MIN) || (mode_d == MODE_ALM_HOUR);
  assign shown    = alm_view ? alm_d : clk_d;

  always_comb begin
    result_o.shown_hour_tens    = shown.ht;
    result_o.shown_hour_units   = shown.hu;
    result_o.shown_minute_tens  = shown.mt;
    result_o.shown_minute_units = shown.mu;
    result_o.current_mode       = mode_d;
    result_o.alarm_on           = alarm_en_d;
    result_o.alarm_ringing      = firing_d;
    result_o.time_set_led       = 1'b0;
    result_o.alarm_set_led      = 1'b0;
    case (mode_d) inside
      MODE_SET_MIN, MODE_SET_HOUR, MODE_ALM_EN: result_o.time_set_led = 1'b1;
      MODE_ALM_MIN, MODE_ALM_HOUR:              result_o.alarm_set_led = 1'b1;
      default:                                  ;
    endcase
  end

  a_firing_on_tick: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(firing_q) |-> $past(fire_i && !item_i.op))
    else $error("firing set without a tick");

  a_enable_holds_on_tick: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (fire_i && !item_i.op) |=> (alarm_en_q == $past(alarm_en_q)))
    else $error("alarm enable changed on a tick");

  a_clock_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (clk_q.mu <= 4'd9) && (clk_q.mt <= 3'd5) &&
    ((clk_q.ht < 2'd2 && clk_q.hu <= 4'd9) || (clk_q.ht == 2'd2 && clk_q.hu <= 4'd3)))
    else $error("clock time out of range");

  a_alarm_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (alm_q.mu <= 4'd9) && (alm_q.mt <= 3'd5) &&
    ((alm_q.ht < 2'd2 && alm_q.hu <= 4'd9) || (alm_q.ht == 2'd2 && alm_q.hu <= 4'd3)))
    else $error("alarm time out of range");

endmodule

// ===== rtl/bac_out_stage.sv =====
// ----------------------------------------------------------------------------
// bac_out_stage
// Result register presenting one display word to the downstream side.
// ----------------------------------------------------------------------------
module bac_out_stage (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             valid_i,
  output logic             ready_o,
  input  bac_pkg::result_t result_i,
  output logic             valid_o,
  input  logic             ready_i,
  output bac_pkg::result_t result_o
);
  import bac_pkg::*;

  logic    valid_q, valid_d;
  result_t result_q;
  logic    load;

  assign ready_o = !valid_q || ready_i;
  assign load    = valid_i && ready_o;

  always_comb begin
    valid_d = valid_q;
    if (load) valid_d = 1'b1;
    else if (ready_i) valid_d = 1'b0;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) valid_q <= 1'b0;
    else valid_q <= valid_d;
  end

  always_ff @(posedge clk_i) begin
    if (load) result_q <= result_i;
  end

  assign valid_o  = valid_q;
  assign result_o = result_q;

endmodule

// ===== rtl/bcd_alarm_clock.sv =====
// ----------------------------------------------------------------------------
// bcd_alarm_clock
// 24-hour BCD clock with alarm, driven by tick and button event words.
//
// Input stream: s_axis_tuser selects the event (0 tick, 1 buttons), and
// s_axis_tdata carries the mode, increment and decrement presses. Every
// accepted word yields one display word on the output stream: shown time
// digits (alarm time in the alarm set modes), mode, alarm flags and leds.
// Configuration: cfg_data_i sets the ticks per second (0 acts as 1); write
// only while no event is in flight. cfg_ready_o is always high.
// The word sits in the input register while the update logic works on it, and
// the result register loads the result when it is empty or being read out.
// Throughput is one word per cycle while the receiver does not stall.
// When the receiver stalls, the result register holds its word and the input
// register still takes one more word; further words wait at s_axis_tready.
// Reset clears the time, alarm, mode, counters and both registers, and sets
// ticks per second to 10.
// ----------------------------------------------------------------------------
module bcd_alarm_clock (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            s_axis_tvalid,
  output logic                            s_axis_tready,
  // mode_press, inc_press, dec_press, zero fill
  input  logic [bac_pkg::InDataW-1:0]     s_axis_tdata,
  // operation
  input  logic                            s_axis_tuser,
  output logic                            m_axis_tvalid,
  input  logic                            m_axis_tready,
  // shown_hour_tens, shown_hour_units, shown_minute_tens, shown_minute_units,
  // current_mode, alarm_on, alarm_ringing, time_set_led, alarm_set_led, zero fill
  output logic [bac_pkg::OutDataW-1:0]    m_axis_tdata,
  input  logic                            cfg_valid_i,
  output logic                            cfg_ready_o,
  input  logic [7:0]                      cfg_data_i
);
  import bac_pkg::*;

  event_t  s_item;
  event_t  in_item;
  logic    in_valid;
  logic    out_ready;
  logic    fire;
  result_t core_result;
  result_t out_result;

  assign s_item.op         = s_axis_tuser;
  assign s_item.mode_press = s_axis_tdata[0];
  assign s_item.inc_press  = s_axis_tdata[1];
  assign s_item.dec_press  = s_axis_tdata[2];

  assign fire        = in_valid && out_ready;
  assign cfg_ready_o = 1'b1;

  bac_in_stage u_in_stage (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (s_axis_tvalid),
    .ready_o (s_axis_tready),
    .item_i  (s_item),
    .take_i  (fire),
    .valid_o (in_valid),
    .item_o  (in_item)
  );

  bac_core u_core (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_valid_i),
    .cfg_data_i (cfg_data_i),
    .fire_i     (fire),
    .item_i     (in_item),
    .result_o   (core_result)
  );

  bac_out_stage u_out_stage (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .valid_i  (in_valid),
    .ready_o  (out_ready),
    .result_i (core_result),
    .valid_o  (m_axis_tvalid),
    .ready_i  (m_axis_tready),
    .result_o (out_result)
  );

  assign m_axis_tdata = {{(OutDataW - $bits(result_t)){1'b0}}, out_result};

endmodule

// ===== verif/bcd_alarm_clock_tb.sv =====
// ----------------------------------------------------------------------------
// bcd_alarm_clock_tb
// Stream-level testbench for the BCD alarm clock. A queue of tick and button
// words feeds a randomly gapped driver; a clocked monitor keeps its own model
// of the clock, predicts the display word for every accepted input word and
// compares each output word field by field. The run moves through several
// tick rates, steers clock and alarm times so that minute and day rollovers
// and alarm hits occur, and stalls the receiver at random and once for long.
// ----------------------------------------------------------------------------
module bcd_alarm_clock_tb;
  import bac_pkg::*;

  localparam int CycleLimit = 500000;

  typedef struct packed {
    logic [7:0] tps;
    logic [7:0] ticks;
    logic [5:0] secs;
    bcd_time_t  wall;
    bcd_time_t  alm;
    logic       en;
    logic [2:0] mode;
    logic       ring;
  } clock_state_t;

  logic                clk_i = 1'b0;
  logic                rst_ni = 1'b0;
  logic                s_axis_tvalid = 1'b0;
  logic                s_axis_tready;
  logic [InDataW-1:0]  s_axis_tdata = '0;
  logic                s_axis_tuser = 1'b0;
  logic                m_axis_tvalid;
  logic                m_axis_tready = 1'b0;
  logic [OutDataW-1:0] m_axis_tdata;
  logic                cfg_valid_i = 1'b0;
  logic                cfg_ready_o;
  logic [7:0]          cfg_data_i = '0;

  event_t       event_backlog[$];
  result_t      display_due[$];
  clock_state_t clock_plan;
  clock_state_t clock_model;
  int           queued_count = 0;
  int           taken_count = 0;
  int           words_out = 0;
  int           cfg_writes = 0;
  int           faults = 0;
  int           cycles = 0;
  logic         in_taken = 1'b0;
  event_t       seen_ev;
  event_t       next_ev;
  logic [InDataW-1:0] next_data;
  int           send_gap = 0;
  int           send_run = 0;
  bit           send_quiet = 1'b0;
  int           sink_gap = 0;
  int           sink_run = 0;
  bit           sink_quiet = 1'b0;
  int           hold_left = 0;
  bit           held_once = 1'b0;

  bcd_alarm_clock u_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_data_i    (cfg_data_i)
  );

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  // bcd time arithmetic
  function automatic bcd_time_t bump_minute(bcd_time_t t);
    bcd_time_t r;
    r = t;
    if (t.mu < 4'd9) begin
      r.mu = t.mu + 4'd1;
    end else begin
      r.mu = 4'd0;
      r.mt = (t.mt < 3'd5) ? t.mt + 3'd1 : 3'd0;
    end
    return r;
  endfunction

  function automatic bcd_time_t drop_minute(bcd_time_t t);
    bcd_time_t r;
    r = t;
    if (t.mu > 4'd0) begin
      r.mu = t.mu - 4'd1;
    end else begin
      r.mu = 4'd9;
      r.mt = (t.mt > 3'd0) ? t.mt - 3'd1 : 3'd5;
    end
    return r;
  endfunction

  function automatic bcd_time_t bump_hour(bcd_time_t t);
    bcd_time_t r;
    r = t;
    if (t.ht >= 2'd2 && t.hu >= 4'd3) begin
      r.ht = 2'd0;
      r.hu = 4'd0;
    end else if (t.hu < 4'd9) begin
      r.hu = t.hu + 4'd1;
    end else begin
      r.hu = 4'd0;
      r.ht = t.ht + 2'd1;
    end
    return r;
  endfunction

  function automatic bcd_time_t drop_hour(bcd_time_t t);
    bcd_time_t r;
    r = t;
    if (t.hu > 4'd0) begin
      r.hu = t.hu - 4'd1;
    end else if (t.ht > 2'd0) begin
      r.hu = 4'd9;
      r.ht = t.ht - 2'd1;
    end else begin
      r.ht = 2'd2;
      r.hu = 4'd3;
    end
    return r;
  endfunction

  function automatic bcd_time_t next_minute(bcd_time_t t);
    bcd_time_t r;
    r = bump_minute(t);
    if (t.mu >= 4'd9 && t.mt >= 3'd5) r = bump_hour(r);
    return r;
  endfunction

  function automatic bcd_time_t prev_minute(bcd_time_t t);
    bcd_time_t r;
    r = drop_minute(t);
    if (t.mu == 4'd0 && t.mt == 3'd0) r = drop_hour(r);
    return r;
  endfunction

  function automatic bcd_time_t to_bcd(int hh, int mm);
    bcd_time_t t;
    t.ht = 2'(hh / 10);
    t.hu = 4'(hh % 10);
    t.mt = 3'(mm / 10);
    t.mu = 4'(mm % 10);
    return t;
  endfunction

  function automatic clock_state_t reset_state();
    clock_state_t s;
    s = '0;
    s.tps = TPS_RESET;
    return s;
  endfunction

  function automatic clock_state_t press_edit(clock_state_t s, logic up);
    clock_state_t r;
    r = s;
    case (s.mode)
      MODE_SET_MIN:  r.wall = up ? bump_minute(s.wall) : drop_minute(s.wall);
      MODE_SET_HOUR: r.wall = up ? bump_hour(s.wall) : drop_hour(s.wall);
      MODE_ALM_MIN:  r.alm = up ? bump_minute(s.alm) : drop_minute(s.alm);
      MODE_ALM_HOUR: r.alm = up ? bump_hour(s.alm) : drop_hour(s.alm);
      MODE_ALM_EN:   r.en = ~s.en;
      default: ;
    endcase
    return r;
  endfunction

  function automatic clock_state_t advance_clock(clock_state_t s, event_t ev);
    clock_state_t r;
    r = s;
    if (ev.op) begin
      if (ev.mode_press) r.mode = (r.mode >= MODE_ALM_EN) ? MODE_NORMAL : r.mode + 3'd1;
      if (ev.inc_press) r = press_edit(r, 1'b1);
      if (ev.dec_press) r = press_edit(r, 1'b0);
    end else if ({1'b0, s.ticks} + 9'd1 < {1'b0, s.tps}) begin
      r.ticks = s.ticks + 8'd1;
    end else begin
      r.ticks = '0;
      if (s.secs < SEC_LAST) begin
        r.secs = s.secs + 6'd1;
      end else begin
        r.secs = '0;
        r.wall = next_minute(s.wall);
        r.ring = s.en && (r.wall == s.alm);
      end
    end
    return r;
  endfunction

  function automatic result_t display_of(clock_state_t s);
    result_t   r;
    bcd_time_t shown;
    logic      alarm_view;
    alarm_view = (s.mode == MODE_ALM_MIN) || (s.mode == MODE_ALM_HOUR);
    shown = alarm_view ? s.alm : s.wall;
    r.shown_hour_tens    = shown.ht;
    r.shown_hour_units   = shown.hu;
    r.shown_minute_tens  = shown.mt;
    r.shown_minute_units = shown.mu;
    r.current_mode       = s.mode;
    r.alarm_on           = s.en;
    r.alarm_ringing      = s.ring;
    r.time_set_led       = (s.mode == MODE_SET_MIN) || (s.mode == MODE_SET_HOUR) ||
                           (s.mode == MODE_ALM_EN);
    r.alarm_set_led      = alarm_view;
    return r;
  endfunction

  function automatic int idle_cycles(bit quiet);
    int roll;
    roll = $urandom_range(0, 99);
    if (quiet || roll < 55) return 0;
    if (roll < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  task automatic check_word(result_t want, logic [OutDataW-1:0] word);
    result_t got;
    string   diff;
    got = word[$bits(result_t)-1:0];
    diff = "";
    if (got.shown_hour_tens != want.shown_hour_tens) diff = {diff, " hour_tens"};
    if (got.shown_hour_units != want.shown_hour_units) diff = {diff, " hour_units"};
    if (got.shown_minute_tens != want.shown_minute_tens) diff = {diff, " minute_tens"};
    if (got.shown_minute_units != want.shown_minute_units) diff = {diff, " minute_units"};
    if (got.current_mode != want.current_mode) diff = {diff, " mode"};
    if (got.alarm_on != want.alarm_on) diff = {diff, " alarm_on"};
    if (got.alarm_ringing != want.alarm_ringing) diff = {diff, " ringing"};
    if (got.time_set_led != want.time_set_led) diff = {diff, " time_led"};
    if (got.alarm_set_led != want.alarm_set_led) diff = {diff, " alarm_led"};
    if (word[OutDataW-1:$bits(result_t)] != '0) diff = {diff, " fill"};
    if (diff != "") begin
      faults++;
      if (faults <= 10)
        $display("word %0d mismatch in%s: expected %06h got %06h", words_out, diff,
                 {{(OutDataW - $bits(result_t)){1'b0}}, want}, word);
    end
  endtask

  // output check first, then prediction for the word taken at this edge
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (m_axis_tvalid && m_axis_tready) begin
        if (display_due.size() == 0) begin
          faults++;
          if (faults <= 10) $display("word %0d arrived with nothing expected: %06h",
                                     words_out, m_axis_tdata);
        end else begin
          check_word(display_due.pop_front(), m_axis_tdata);
        end
        words_out++;
      end
      if (cfg_valid_i && cfg_ready_o) begin
        clock_model.tps = cfg_data_i;
        cfg_writes++;
      end
      in_taken = s_axis_tvalid && s_axis_tready;
      if (in_taken) begin
        seen_ev.op         = s_axis_tuser;
        seen_ev.mode_press = s_axis_tdata[0];
        seen_ev.inc_press  = s_axis_tdata[1];
        seen_ev.dec_press  = s_axis_tdata[2];
        clock_model = advance_clock(clock_model, seen_ev);
        display_due.push_back(display_of(clock_model));
        taken_count++;
      end
    end
  end

  always @(posedge clk_i) begin
    cycles++;
    if (cycles > CycleLimit) begin
      $display("== FAIL ==");
      $finish;
    end
  end

  // input driver
  always @(negedge clk_i) begin
    if (!rst_ni) begin
      s_axis_tvalid <= 1'b0;
    end else if (!s_axis_tvalid || in_taken) begin
      if (send_gap > 0) begin
        send_gap--;
        s_axis_tvalid <= 1'b0;
      end else if (event_backlog.size() > 0) begin
        next_ev = event_backlog.pop_front();
        next_data = '0;
        next_data[0] = next_ev.mode_press;
        next_data[1] = next_ev.inc_press;
        next_data[2] = next_ev.dec_press;
        s_axis_tuser  <= next_ev.op;
        s_axis_tdata  <= next_data;
        s_axis_tvalid <= 1'b1;
        if (send_run == 0) begin
          send_run = $urandom_range(16, 64);
          send_quiet = ($urandom_range(0, 3) == 0);
        end
        send_run--;
        send_gap = idle_cycles(send_quiet);
      end else begin
        s_axis_tvalid <= 1'b0;
      end
    end
  end

  // output ready, with one long hold-off
  always @(negedge clk_i) begin
    if (!rst_ni) begin
      m_axis_tready <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left--;
      m_axis_tready <= 1'b0;
    end else if (!held_once && taken_count >= 120) begin
      held_once = 1'b1;
      hold_left = 60;
      m_axis_tready <= 1'b0;
    end else if (sink_gap > 0) begin
      sink_gap--;
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= 1'b1;
      if (sink_run == 0) begin
        sink_run = $urandom_range(16, 64);
        sink_quiet = ($urandom_range(0, 3) == 0);
      end
      sink_run--;
      sink_gap = idle_cycles(sink_quiet);
    end
  end

  task automatic post(logic op, logic mp, logic ip, logic dp);
    event_t ev;
    ev.op = op;
    ev.mode_press = mp;
    ev.inc_press = ip;
    ev.dec_press = dp;
    clock_plan = advance_clock(clock_plan, ev);
    event_backlog.push_back(ev);
    queued_count++;
  endtask

  task automatic settle(int extra);
    while (taken_count != queued_count || display_due.size() != 0) @(negedge clk_i);
    repeat (extra) @(negedge clk_i);
  endtask

  task automatic write_tps(logic [7:0] value);
    int seen;
    settle(4);
    seen = cfg_writes;
    cfg_data_i  <= value;
    cfg_valid_i <= 1'b1;
    do @(negedge clk_i); while (cfg_writes == seen);
    cfg_valid_i <= 1'b0;
    clock_plan.tps = value;
  endtask

  task automatic goto_mode(logic [2:0] m);
    while (clock_plan.mode != m) post(1'b1, 1'b1, 1'b0, 1'b0);
  endtask

  task automatic steer(logic [2:0] m, bcd_time_t goal);
    bcd_time_t cur;
    logic      hour;
    int        span, cur_v, goal_v, step;
    goto_mode(m);
    hour = (m == MODE_SET_HOUR) || (m == MODE_ALM_HOUR);
    cur = (m == MODE_SET_MIN || m == MODE_SET_HOUR) ? clock_plan.wall : clock_plan.alm;
    span = hour ? 24 : 60;
    cur_v = hour ? cur.ht * 10 + cur.hu : cur.mt * 10 + cur.mu;
    goal_v = hour ? goal.ht * 10 + goal.hu : goal.mt * 10 + goal.mu;
    step = (goal_v - cur_v + span) % span;
    if ($urandom_range(0, 7) == 0) post(1'b1, 1'b0, 1'b1, 1'b1);
    if (step <= span / 2) repeat (step) post(1'b1, 1'b0, 1'b1, 1'b0);
    else repeat (span - step) post(1'b1, 1'b0, 1'b0, 1'b1);
  endtask

  // set clock one minute short of the wake time, then tick through the rollover
  task automatic wake_run(bcd_time_t wake, logic arm);
    bcd_time_t pre, start;
    logic      up;
    pre = prev_minute(wake);
    if ($urandom_range(0, 1)) begin
      steer(MODE_SET_MIN, pre);
      steer(MODE_SET_HOUR, pre);
      steer(MODE_ALM_MIN, wake);
      steer(MODE_ALM_HOUR, wake);
    end else begin
      steer(MODE_ALM_HOUR, wake);
      steer(MODE_ALM_MIN, wake);
      steer(MODE_SET_HOUR, pre);
      steer(MODE_SET_MIN, pre);
    end
    goto_mode(MODE_ALM_EN);
    up = 1'($urandom_range(0, 1));
    if (clock_plan.en != arm) post(1'b1, 1'b0, up, ~up);
    goto_mode(3'($urandom_range(0, 5)));
    start = clock_plan.wall;
    while (clock_plan.wall == start)
      post(1'b0, 1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)),
           1'($urandom_range(0, 1)));
    if ($urandom_range(0, 2) == 0) begin
      goto_mode(MODE_ALM_EN);
      post(1'b1, 1'b0, 1'b1, 1'b0);
    end
    repeat ($urandom_range(0, 6)) post(1'b0, 1'b0, 1'b0, 1'b0);
  endtask

  task automatic noise_burst(int n);
    repeat (n)
      post(1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)),
           1'($urandom_range(0, 1)));
  endtask

  task automatic random_rounds(int budget);
    int        start;
    bcd_time_t wake;
    start = queued_count;
    while (queued_count - start < budget) begin
      if ($urandom_range(0, 2) == 0) begin
        noise_burst($urandom_range(4, 20));
      end else begin
        if ($urandom_range(0, 1)) wake = next_minute(clock_plan.wall);
        else wake = to_bcd($urandom_range(0, 23), $urandom_range(0, 59));
        wake_run(wake, $urandom_range(0, 4) != 0);
      end
    end
  endtask

  initial begin
    clock_plan  = reset_state();
    clock_model = reset_state();
    repeat (8) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // buttons ignored on a tick, edits in every mode, all wraps
    post(1'b0, 1'b1, 1'b1, 1'b1);
    post(1'b1, 1'b0, 1'b0, 1'b0);
    post(1'b1, 1'b0, 1'b1, 1'b0);
    post(1'b1, 1'b0, 1'b0, 1'b1);
    post(1'b1, 1'b1, 1'b0, 1'b0);
    post(1'b1, 1'b0, 1'b0, 1'b1);
    post(1'b1, 1'b0, 1'b1, 1'b0);
    post(1'b1, 1'b0, 1'b1, 1'b1);
    post(1'b1, 1'b1, 1'b1, 1'b0);
    post(1'b1, 1'b0, 1'b0, 1'b1);
    post(1'b1, 1'b0, 1'b0, 1'b1);
    post(1'b1, 1'b0, 1'b1, 1'b0);
    post(1'b1, 1'b1, 1'b0, 1'b1);
    post(1'b1, 1'b0, 1'b1, 1'b0);
    post(1'b1, 1'b1, 1'b0, 1'b1);
    post(1'b1, 1'b0, 1'b1, 1'b0);
    post(1'b1, 1'b1, 1'b1, 1'b0);
    post(1'b1, 1'b0, 1'b0, 1'b1);
    post(1'b1, 1'b0, 1'b1, 1'b1);
    post(1'b1, 1'b0, 1'b1, 1'b0);
    post(1'b1, 1'b1, 1'b1, 1'b1);
    post(1'b0, 1'b0, 1'b0, 1'b0);
    post(1'b0, 1'b1, 1'b0, 1'b0);
    post(1'b1, 1'b1, 1'b1, 1'b1);

    write_tps(8'd255);
    repeat (30) post(1'b0, 1'b0, 1'b0, 1'b0);
    noise_burst(10);

    // lower rate while counting, second ends at the next tick
    write_tps(8'd3);
    noise_burst(25);

    write_tps(8'd0);
    wake_run(to_bcd(0, 0), 1'b1);
    random_rounds(80);

    write_tps(8'd1);
    random_rounds(100);

    write_tps(8'($urandom_range(1, 2)));
    random_rounds(60);

    settle(10);
    if (faults == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule

// ===== files.f =====
rtl/bac_pkg.sv
rtl/bac_in_stage.sv
rtl/bac_core.sv
rtl/bac_out_stage.sv
rtl/bcd_alarm_clock.sv
verif/bcd_alarm_clock_tb.sv
